/* hw/rtl/dual_ring_message_queue_round_robin_defines.svh */
// Assertion helpers shared by the queue RTL.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef DUAL_RING_MESSAGE_QUEUE_ROUND_ROBIN_DEFINES_SVH
`define DUAL_RING_MESSAGE_QUEUE_ROUND_ROBIN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DRMQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DRMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/drmq_pkg.sv */
package drmq_pkg;

    // Sizes
    localparam int RING_DEPTH  = 4096;
    localparam int MAX_MESSAGE = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int SZ_W     = PTR_W + 1;
    localparam int STORE_AW = PTR_W + 1;
    localparam int CFG_W    = 13;
    localparam int CNT_W    = 13;
    localparam int BUF_AW   = $clog2(MAX_MESSAGE);
    localparam int LEN_W    = $clog2(MAX_MESSAGE + 2);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CFG_W-1:0] RING_SIZE_RESET = CFG_W'(4096);

    // Characters
    localparam logic [7:0] TERM_CHAR = 8'h24;
    localparam logic [7:0] TAG_ZERO  = 8'h30;
    localparam logic [7:0] NUL_CHAR  = 8'h00;

    // Request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Command passed from front to back
    typedef struct packed {
        logic       is_pop;
        logic       chan;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_SINGLE
    } t_back_state;

    // Clamp the configured ring size to 1..RING_DEPTH
    function automatic logic [SZ_W-1:0] size_in_effect(input logic [CFG_W-1:0] cfg);
        logic [31:0] c;
        c = 32'(cfg);
        if (c == 32'd0) begin
            c = 32'd1;
        end
        if (c > 32'(RING_DEPTH)) begin
            c = 32'(RING_DEPTH);
        end
        return c[SZ_W-1:0];
    endfunction

    // Step a ring pointer, wrapping at the size in effect
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                     input logic [SZ_W-1:0]  s);
        logic [SZ_W-1:0] nx;
        nx = {1'b0, p} + 1'b1;
        return (nx >= s) ? '0 : nx[PTR_W-1:0];
    endfunction

endpackage

/* hw/rtl/drmq_ram.sv */
module drmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/drmq_front.sv */
`include "dual_ring_message_queue_round_robin_defines.svh"

module drmq_front
    import drmq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic [0:0] i_s_tuser,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    logic                r_expect_tag;
    logic                n_expect_tag;
    logic                r_tag_chan;
    logic                n_tag_chan;
    t_cmd                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                in_take;
    logic                enq;
    logic                deq;
    t_cmd                enq_cmd;

    assign o_s_tready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign in_take    = i_s_tvalid && o_s_tready;

    // Classify: drop nul bytes, absorb tags, queue payload pushes and pops
    always_comb begin
        enq          = 1'b0;
        n_expect_tag = r_expect_tag;
        n_tag_chan   = r_tag_chan;
        enq_cmd      = '{is_pop: i_s_tuser[0], chan: r_tag_chan, data: i_s_tdata};
        if (in_take) begin
            if (i_s_tuser[0] == REQ_POP) begin
                enq = 1'b1;
            end else if (i_s_tdata != NUL_CHAR) begin
                if (r_expect_tag) begin
                    n_tag_chan   = (i_s_tdata != TAG_ZERO);
                    n_expect_tag = 1'b0;
                end else begin
                    enq = 1'b1;
                    if (i_s_tdata == TERM_CHAR) begin
                        n_expect_tag = 1'b1;
                    end
                end
            end
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign deq         = o_cmd_valid && i_cmd_ready;

    // Tag state and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_tag <= 1'b1;
            r_tag_chan   <= 1'b0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
        end else begin
            r_expect_tag <= n_expect_tag;
            r_tag_chan   <= n_tag_chan;
            if (enq) begin
                r_wp <= QUEUE_AW'(r_wp + 1'b1);
            end
            if (deq) begin
                r_rp <= QUEUE_AW'(r_rp + 1'b1);
            end
            if (enq && !deq) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (deq && !enq) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= enq_cmd;
        end
    end

    `DRMQ_ASSERT_SAME(a_queue_bound, 1'b1, r_cnt <= QCNT_W'(QUEUE_DEPTH), "queue over-filled")
    `DRMQ_ASSERT_NEXT(a_tag_absorbed, in_take && r_expect_tag && i_s_tuser[0] == REQ_PUSH && i_s_tdata != NUL_CHAR, !r_expect_tag && r_tag_chan == $past(i_s_tdata != TAG_ZERO), "tag not taken")

endmodule

/* hw/rtl/drmq_back.sv */
`include "dual_ring_message_queue_round_robin_defines.svh"

module drmq_back
    import drmq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_ring_size,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_ready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    output logic [2:0]       o_m_tuser
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [PTR_W-1:0] r_wp [2];
    logic [PTR_W-1:0] r_rp [2];
    logic [CNT_W-1:0] r_cnt [2];
    logic             r_last_served;
    logic             r_chan;
    logic [PTR_W-1:0] r_ip;
    logic [PTR_W-1:0] r_cp;
    logic             r_dv;
    logic [LEN_W-1:0] r_n;
    logic [SZ_W-1:0]  r_scanned;
    logic [LEN_W-1:0] r_len;
    logic             r_trunc;
    logic [LEN_W-1:0] r_k;
    logic             r_empty;
    logic             r_ov;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_oempty;
    logic             r_ochan;
    logic             r_otrunc;

    logic [SZ_W-1:0]     s;
    logic                out_free;
    logic                pick_first;
    logic                pick_other;
    logic                pop_any;
    logic                pop_chan;
    logic                is_term;
    logic                at_end;
    logic                scan_done;
    logic [LEN_W-1:0]    n_after;
    logic [LEN_W-1:0]    k_inc;
    logic                emit_last;
    logic                cmd_take;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [STORE_AW-1:0] store_raddr;
    logic [7:0]          store_rdata;
    logic                buf_we;
    logic [BUF_AW-1:0]   buf_waddr;
    logic [BUF_AW-1:0]   buf_raddr;
    logic [7:0]          buf_rdata;
    logic                out_load;

    assign s        = size_in_effect(i_ring_size);
    assign out_free = !r_ov || i_m_tready;

    // Round-robin pick: the ring after the last one served goes first
    assign pick_first = (r_cnt[r_last_served] != '0);
    assign pick_other = (r_cnt[~r_last_served] != '0);
    assign pop_any    = pick_first || pick_other;
    assign pop_chan   = pick_first ? r_last_served : ~r_last_served;

    // Scan check on the byte returned by the ring store
    assign is_term   = (store_rdata == TERM_CHAR);
    assign at_end    = (SZ_W'(r_scanned + 1'b1) == s);
    assign scan_done = r_dv && (is_term || at_end);
    assign n_after   = (is_term || r_n == LEN_W'(MAX_MESSAGE + 1)) ? r_n
                                                                : LEN_W'(r_n + 1'b1);

    assign k_inc     = LEN_W'(r_k + 1'b1);
    assign emit_last = (k_inc == r_len);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_pop == REQ_POP) begin
                    n_state = pop_any ? ST_SCAN : ST_SINGLE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = (n_after == '0) ? ST_SINGLE : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb begin
        o_cmd_ready = 1'b0;
        store_we    = 1'b0;
        buf_we      = 1'b0;
        out_load    = 1'b0;
        buf_raddr   = r_k[BUF_AW-1:0];
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                store_we    = i_cmd_valid && (i_cmd.is_pop == REQ_PUSH);
            end
            ST_SCAN: begin
                buf_we = r_dv && !is_term && (r_n < LEN_W'(MAX_MESSAGE));
            end
            ST_EMIT_WR: begin
                out_load = out_free;
                if (out_free && !emit_last) begin
                    buf_raddr = k_inc[BUF_AW-1:0];
                end
            end
            ST_SINGLE: begin
                out_load = out_free;
            end
            default: begin
                o_cmd_ready = 1'b0;
            end
        endcase
    end

    assign cmd_take    = i_cmd_valid && o_cmd_ready;
    assign store_waddr = {i_cmd.chan, r_wp[i_cmd.chan]};
    assign store_raddr = {r_chan, r_ip};
    assign buf_waddr   = r_n[BUF_AW-1:0];

    // Control and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wp[0]       <= '0;
            r_wp[1]       <= '0;
            r_rp[0]       <= '0;
            r_rp[1]       <= '0;
            r_cnt[0]      <= '0;
            r_cnt[1]      <= '0;
            r_last_served <= 1'b0;
            r_dv          <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            r_state <= n_state;
            // Push or start a pop
            if (cmd_take) begin
                if (i_cmd.is_pop == REQ_PUSH) begin
                    r_wp[i_cmd.chan] <= ptr_advance(r_wp[i_cmd.chan], s);
                    if (i_cmd.data == TERM_CHAR && r_cnt[i_cmd.chan] != COUNT_MAX) begin
                        r_cnt[i_cmd.chan] <= CNT_W'(r_cnt[i_cmd.chan] + 1'b1);
                    end
                end else if (pop_any) begin
                    r_last_served <= ~pop_chan;
                    r_dv          <= 1'b0;
                end
            end
            // Keep one ring read in flight while scanning
            if (r_state == ST_SCAN) begin
                r_dv <= 1'b1;
                if (scan_done) begin
                    r_rp[r_chan]  <= ptr_advance(r_cp, s);
                    r_cnt[r_chan] <= CNT_W'(r_cnt[r_chan] - 1'b1);
                end
            end
            // Output register
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Scan, emit and output payload
    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.is_pop == REQ_POP) begin
            r_chan    <= pop_any ? pop_chan : 1'b0;
            r_empty   <= !pop_any;
            r_ip      <= r_rp[pop_chan];
            r_n       <= '0;
            r_scanned <= '0;
        end
        if (r_state == ST_SCAN) begin
            r_ip <= ptr_advance(r_ip, s);
            r_cp <= r_ip;
            if (r_dv) begin
                r_n       <= n_after;
                r_scanned <= SZ_W'(r_scanned + 1'b1);
            end
            if (scan_done) begin
                r_empty <= 1'b0;
                r_trunc <= (n_after > LEN_W'(MAX_MESSAGE));
                r_len   <= (n_after > LEN_W'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE) : n_after;
                r_k     <= '0;
            end
        end
        if (r_state == ST_EMIT_WR && out_free && !emit_last) begin
            r_k <= k_inc;
        end
        if (out_load) begin
            if (r_state == ST_EMIT_WR) begin
                r_obyte  <= buf_rdata;
                r_olast  <= emit_last;
                r_oempty <= 1'b0;
                r_ochan  <= r_chan;
                r_otrunc <= r_trunc;
            end else begin
                r_obyte  <= NUL_CHAR;
                r_olast  <= 1'b1;
                r_oempty <= r_empty;
                r_ochan  <= r_chan;
                r_otrunc <= 1'b0;
            end
        end
    end

    // Both rings share one store, ring number in the top address bit
    drmq_ram #(
        .WIDTH (8),
        .DEPTH (2 * RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // Message buffer: collects up to MAX_MESSAGE bytes before they go out
    drmq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE)
    ) u_msg_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (store_rdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = {r_otrunc, r_ochan, r_oempty};

    `DRMQ_ASSERT_SAME(a_scan_has_msg, r_state == ST_SCAN, r_cnt[r_chan] != '0, "scan on empty ring")
    `DRMQ_ASSERT_SAME(a_emit_index, r_state == ST_EMIT_WR, r_len != '0 && r_k < r_len, "emit index out of range")
    `DRMQ_ASSERT_SAME(a_trunc_len, r_state == ST_EMIT_WR && r_trunc, r_len == LEN_W'(MAX_MESSAGE), "cut message not full length")
    `DRMQ_ASSERT_SAME(a_empty_item, r_ov && r_oempty, r_olast && !r_ochan && !r_otrunc && r_obyte == NUL_CHAR, "bad empty item")

endmodule

/* hw/rtl/dual_ring_message_queue_round_robin.sv */
// Channel  Direction  tdata           tuser                                   tlast
// s        in         data_byte[7:0]  [0] req_type                            -
// m        out        out_byte[7:0]   [0] queue_empty [1] from_channel        last_byte
//                                     [2] truncated
// cfg      in         ring_size[12:0] write on i_cfg_we                       -
//
// Push: written to the ring store while the back end is idle; a two-entry command queue
// sits behind the input. Pop: the back end scans the ring up to and including the '$' (at
// most the ring size in effect), primes the message buffer, then returns the bytes.
// Empty queue or a message of only '$': either gives a single item.
// Reset is synchronous and clears pointers, counts and tag state at once; ring contents
// are left as they are. A stalled output holds the back end while the front keeps filling.
`include "dual_ring_message_queue_round_robin_defines.svh"

module dual_ring_message_queue_round_robin
    import drmq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]       i_s_tuser,   // [0] req_type
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tlast,
    output logic [2:0]       o_m_tuser,   // [0] queue_empty, [1] from_channel, [2] truncated
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_ring_size;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;

    // Ring size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_ring_size <= i_cfg_wdata;
        end
    end

    drmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    drmq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ring_size (r_ring_size),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

/* sim/dual_ring_message_queue_round_robin_tb.sv */
module dual_ring_message_queue_round_robin_tb;
    import drmq_pkg::*;

    localparam int PERIOD        = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PERCENT  = 24;
    localparam int SHOWN_ERRORS  = 10;

    // One predicted output item of a pop
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       chan;
        logic       trunc;
    } t_msg_byte;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata   = '0;   // [7:0] data_byte
    logic [0:0]       i_s_tuser   = '0;   // [0] req_type
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [7:0]       o_m_tdata;          // [7:0] out_byte
    logic             o_m_tlast;
    logic [2:0]       o_m_tuser;          // [0] queue_empty, [1] from_channel, [2] truncated
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = RING_SIZE_RESET;

    // Predicted queue state
    logic [7:0]       ring_mem [2][RING_DEPTH];
    bit               ring_written [2][RING_DEPTH];
    int unsigned      wr_ptr [2];
    int unsigned      rd_ptr [2];
    int unsigned      msg_count [2];
    bit               want_tag;
    bit               tag_ring;
    bit               rr_first;
    logic [CFG_W-1:0] ring_size_cfg;

    t_msg_byte        pending_bytes [$];
    t_msg_byte        want_byte;
    int               mismatches;
    int               items_accepted;
    bit               no_idle;

    dual_ring_message_queue_round_robin uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // Stall the output side at random unless a clean stretch is running
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each accepted output item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("unexpected output item at %0t: byte %02h last %b user %b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                end
            end else begin
                want_byte = pending_bytes.pop_front();
                if (o_m_tdata !== want_byte.data || o_m_tlast !== want_byte.last ||
                    o_m_tuser[0] !== want_byte.empty || o_m_tuser[1] !== want_byte.chan ||
                    o_m_tuser[2] !== want_byte.trunc) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("mismatch at %0t: want byte %02h last %b empty %b chan %b trunc %b",
                                 $time, want_byte.data, want_byte.last, want_byte.empty,
                                 want_byte.chan, want_byte.trunc);
                        $display("                 got byte %02h last %b empty %b chan %b trunc %b",
                                 o_m_tdata, o_m_tlast, o_m_tuser[0], o_m_tuser[1],
                                 o_m_tuser[2]);
                    end
                end
            end
        end
    end

    // Ring length in force: zero counts as one, anything past the store as the store
    function automatic int unsigned ring_span();
        if (ring_size_cfg == '0) begin
            return 1;
        end
        if (ring_size_cfg > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return 32'(ring_size_cfg);
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned span);
        return (p + 1 >= span) ? 0 : p + 1;
    endfunction

    function automatic void clear_prediction();
        wr_ptr        = '{0, 0};
        rd_ptr        = '{0, 0};
        msg_count     = '{0, 0};
        want_tag      = 1'b1;
        tag_ring      = 1'b0;
        rr_first      = 1'b0;
        ring_size_cfg = RING_SIZE_RESET;
        mismatches    = 0;
        items_accepted = 0;
    endfunction

    // Track a pushed byte: take a tag, or store into the tagged ring
    function automatic void store_pushed_byte(input logic [7:0] b);
        int unsigned p;
        int unsigned span;
        span = ring_span();
        if (b == NUL_CHAR) begin
            return;
        end
        if (want_tag) begin
            tag_ring = (b != TAG_ZERO);
            want_tag = 1'b0;
            return;
        end
        p = wr_ptr[tag_ring];
        ring_mem[tag_ring][p]     = b;
        ring_written[tag_ring][p] = 1'b1;
        if (b == TERM_CHAR) begin
            if (msg_count[tag_ring] < COUNT_MAX) begin
                msg_count[tag_ring]++;
            end
            want_tag = 1'b1;
        end
        wr_ptr[tag_ring] = step_ptr(p, span);
    endfunction

    // Serve one message in round-robin order and queue its output items.
    // With apply clear, only report whether the scan stays on written entries.
    function automatic bit serve_message(input bit apply);
        int unsigned span;
        int unsigned p;
        int unsigned n;
        int unsigned count;
        bit          r;
        logic [7:0]  taken [MAX_MESSAGE];
        t_msg_byte   res;
        span = ring_span();
        n    = 0;
        if (msg_count[rr_first] > 0) begin
            r = rr_first;
        end else if (msg_count[!rr_first] > 0) begin
            r = !rr_first;
        end else begin
            if (apply) begin
                res.data  = NUL_CHAR;
                res.last  = 1'b1;
                res.empty = 1'b1;
                res.chan  = 1'b0;
                res.trunc = 1'b0;
                pending_bytes.push_back(res);
            end
            return 1'b1;
        end
        // Scan up to the terminator, or a whole ring when it has been overwritten
        p = rd_ptr[r];
        for (int unsigned i = 0; i < span; i++) begin
            if (!ring_written[r][p]) begin
                return 1'b0;
            end
            if (ring_mem[r][p] == TERM_CHAR) begin
                p = step_ptr(p, span);
                break;
            end
            if (n < MAX_MESSAGE) begin
                taken[n] = ring_mem[r][p];
            end
            n++;
            p = step_ptr(p, span);
        end
        if (!apply) begin
            return 1'b1;
        end
        rr_first  = !r;
        rd_ptr[r] = p;
        msg_count[r]--;
        res.empty = 1'b0;
        res.chan  = r;
        if (n == 0) begin
            res.data  = NUL_CHAR;
            res.last  = 1'b1;
            res.trunc = 1'b0;
            pending_bytes.push_back(res);
            return 1'b1;
        end
        res.trunc = (n > MAX_MESSAGE);
        count     = res.trunc ? MAX_MESSAGE : n;
        for (int unsigned i = 0; i < count; i++) begin
            res.data = taken[i];
            res.last = (i + 1 == count);
            pending_bytes.push_back(res);
        end
        return 1'b1;
    endfunction

    // Offer one item after a random idle gap; update the prediction once accepted
    task automatic send_item(input logic req, input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= b;
        i_s_tuser[0] <= req;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        items_accepted++;
        if (req == REQ_POP) begin
            void'(serve_message(1'b1));
        end else begin
            store_pushed_byte(b);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_item(REQ_PUSH, b);
    endtask

    // Pop only when the scan cannot touch an entry that was never written
    task automatic request_pop();
        if (serve_message(1'b0)) begin
            send_item(REQ_POP, 8'($urandom));
        end
    endtask

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == TERM_CHAR) begin
            b = 8'h5A;
        end
        return b;
    endfunction

    // Tag, payload of random bytes, and optionally the terminator
    task automatic push_message(input logic [7:0] tag, input int unsigned len, input bit close);
        push_byte(tag);
        repeat (len) begin
            push_byte(payload_byte());
        end
        if (close) begin
            push_byte(TERM_CHAR);
        end
    endtask

    // Hold the input until every predicted output item has arrived, then let it settle
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_ring_size(input logic [CFG_W-1:0] v);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        ring_size_cfg = v;
    endtask

    task automatic pop_all();
        while ((msg_count[0] != 0 || msg_count[1] != 0) && serve_message(1'b0)) begin
            send_item(REQ_POP, 8'($urandom));
        end
    endtask

    // Empty queue, tag routing, ignored zero bytes, empty message, round-robin order
    task automatic test_routing_and_order();
        request_pop();
        push_byte(NUL_CHAR);
        push_byte(TAG_ZERO);
        push_byte(8'h01);
        push_byte(NUL_CHAR);
        push_byte(8'hFF);
        push_byte(TERM_CHAR);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(TERM_CHAR);
        push_byte(8'h41);
        push_byte(TERM_CHAR);
        push_byte(8'h01);
        push_byte(8'hFE);
        push_byte(TERM_CHAR);
        repeat (5) begin
            request_pop();
        end
        wait_for_results();
    endtask

    // A message past the limit is cut and flagged; sent with no idle cycles on either side
    task automatic test_long_message();
        no_idle = 1'b1;
        push_message(TAG_ZERO, MAX_MESSAGE + 1, 1'b1);
        request_pop();
        wait_for_results();
        no_idle = 1'b0;
    endtask

    // Oversized setting clamps to the store; a tiny ring loses its terminator
    task automatic test_clamp_and_lost_terminator();
        set_ring_size({CFG_W{1'b1}});
        push_message(8'h31, 3, 1'b1);
        request_pop();
        set_ring_size(CFG_W'(4));
        push_byte(TAG_ZERO);
        push_byte(8'h61);
        push_byte(8'h62);
        push_byte(TERM_CHAR);
        push_byte(TAG_ZERO);
        push_byte(8'h63);
        push_byte(8'h64);
        push_byte(8'h65);
        push_byte(8'h66);
        request_pop();
        push_byte(TERM_CHAR);
        request_pop();
        request_pop();
        wait_for_results();
    endtask

    // Mostly whole messages with random content, some pops, some broken pushes
    task automatic random_phase(input logic [CFG_W-1:0] size, input int target);
        int          start;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  tag;
        set_ring_size(size);
        start = items_accepted;
        while (items_accepted - start < target) begin
            pick = $urandom_range(99);
            tag  = ($urandom_range(1) != 0) ? TAG_ZERO : 8'($urandom_range(1, 255));
            len  = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
            if (pick < 32) begin
                request_pop();
            end else if (pick < 85) begin
                push_message(tag, len, 1'b1);
            end else if (pick < 93) begin
                push_message(tag, $urandom_range(0, 4), 1'b0);
            end else begin
                push_byte(8'($urandom));
            end
        end
        pop_all();
    endtask

    task automatic test_random_traffic();
        random_phase(RING_SIZE_RESET, 22);
        random_phase(CFG_W'(5), 20);
        random_phase(CFG_W'(13), 20);
    endtask

    initial begin
        clear_prediction();
        no_idle = 1'b0;
        repeat (11) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_routing_and_order();
        test_long_message();
        test_clamp_and_lost_terminator();
        test_random_traffic();
        wait_for_results();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/drmq_pkg.sv
hw/rtl/drmq_ram.sv
hw/rtl/drmq_front.sv
hw/rtl/drmq_back.sv
hw/rtl/dual_ring_message_queue_round_robin.sv
sim/dual_ring_message_queue_round_robin_tb.sv
